@@ src/ccsd_pkg.sv @@
// Shared types, identifiers and decode functions for the cabin status decoder.
package ccsd_pkg;

  // Frame identifiers that carry cabin status
  localparam logic [10:0] ID_SEAT_FL    = 11'h496;
  localparam logic [10:0] ID_SEAT_FR    = 11'h475;
  localparam logic [10:0] ID_REAR_LEFT  = 11'h438;
  localparam logic [10:0] ID_REAR_RIGHT = 11'h453;
  localparam logic [10:0] ID_AIRCON     = 11'h382;
  localparam logic [10:0] ID_SYNC       = 11'h383;
  localparam logic [10:0] ID_MODE       = 11'h384;
  localparam logic [10:0] ID_STEER      = 11'h418;

  // Data byte codes
  localparam logic [7:0] FRONT_HEAT3 = 8'h46;
  localparam logic [7:0] FRONT_HEAT2 = 8'h3E;
  localparam logic [7:0] FRONT_HEAT1 = 8'h36;
  localparam logic [7:0] FRONT_VENT3 = 8'h2E;
  localparam logic [7:0] FRONT_VENT2 = 8'h26;
  localparam logic [7:0] FRONT_VENT1 = 8'h1E;
  localparam logic [7:0] REAR_HEAT2  = 8'h41;
  localparam logic [7:0] REAR_HEAT1  = 8'h31;
  localparam logic [7:0] AIRCON_ON_A = 8'h05;
  localparam logic [7:0] AIRCON_ON_B = 8'h09;
  localparam logic [7:0] SYNC_ON     = 8'h10;
  localparam logic [7:0] STEER_ON    = 8'h01;

  // Bit positions in the mode byte
  localparam int MODE_DRIVER_BIT = 4;
  localparam int MODE_HEAT_BIT   = 0;

  // Default depth of the queue between decode and update
  localparam int FIFO_DEPTH_DEF = 2;

  // Which part of the status a decoded word updates
  typedef enum logic [3:0] {
    GRP_NONE,
    GRP_SEAT_FL,
    GRP_SEAT_FR,
    GRP_SEAT_RL,
    GRP_SEAT_RR,
    GRP_AIRCON,
    GRP_SYNC,
    GRP_MODE,
    GRP_STEER
  } upd_grp_t;

  // Decoded update word: val_a is heat / single flag, val_b is vent / second flag
  typedef struct packed {
    upd_grp_t   grp;
    logic [1:0] val_a;
    logic [1:0] val_b;
  } upd_t;

  // Full cabin status, in report order
  typedef struct packed {
    logic [1:0] front_left_heat;
    logic [1:0] front_left_vent;
    logic [1:0] front_right_heat;
    logic [1:0] front_right_vent;
    logic [1:0] rear_left_heat;
    logic [1:0] rear_right_heat;
    logic       aircon_on;
    logic       sync_on;
    logic       driver_only_on;
    logic       heat_mode_on;
    logic       steering_heat_on;
  } cabin_status_t;

  // Front seat heat level from the seat code
  function automatic logic [1:0] front_heat(input logic [7:0] code);
    logic [1:0] lvl;
    lvl = 2'd0;
    if (code == FRONT_HEAT3) lvl = 2'd3;
    else if (code == FRONT_HEAT2) lvl = 2'd2;
    else if (code == FRONT_HEAT1) lvl = 2'd1;
    return lvl;
  endfunction

  // Front seat vent level from the seat code
  function automatic logic [1:0] front_vent(input logic [7:0] code);
    logic [1:0] lvl;
    lvl = 2'd0;
    if (code == FRONT_VENT3) lvl = 2'd3;
    else if (code == FRONT_VENT2) lvl = 2'd2;
    else if (code == FRONT_VENT1) lvl = 2'd1;
    return lvl;
  endfunction

  // Rear seat heat level from the seat code
  function automatic logic [1:0] rear_heat(input logic [7:0] code);
    logic [1:0] lvl;
    lvl = 2'd0;
    if (code == REAR_HEAT2) lvl = 2'd2;
    else if (code == REAR_HEAT1) lvl = 2'd1;
    return lvl;
  endfunction

endpackage

@@ src/ccsd_front.sv @@
// Front end: classifies a received frame by identifier and decodes its data bytes.
module ccsd_front
  import ccsd_pkg::*;
(
  input  logic [10:0] frame_id,
  input  logic [3:0]  length_code,
  input  logic [7:0]  byte0,
  input  logic [7:0]  byte3,
  input  logic [7:0]  byte4,
  input  logic [7:0]  byte6,
  output logic        keep,
  output upd_t        upd
);

  // Zero length frames are dropped
  assign keep = (length_code != 4'd0);

  // Identifier decode and byte decode
  always_comb begin
    upd = '{grp: GRP_NONE, val_a: 2'd0, val_b: 2'd0};
    unique case (frame_id)
      ID_SEAT_FL: begin
        upd.grp   = GRP_SEAT_FL;
        upd.val_a = front_heat(byte0);
        upd.val_b = front_vent(byte0);
      end
      ID_SEAT_FR: begin
        upd.grp   = GRP_SEAT_FR;
        upd.val_a = front_heat(byte0);
        upd.val_b = front_vent(byte0);
      end
      ID_REAR_LEFT: begin
        upd.grp   = GRP_SEAT_RL;
        upd.val_a = rear_heat(byte0);
      end
      ID_REAR_RIGHT: begin
        upd.grp   = GRP_SEAT_RR;
        upd.val_a = rear_heat(byte0);
      end
      ID_AIRCON: begin
        upd.grp   = GRP_AIRCON;
        upd.val_a = {1'b0, (byte6 == AIRCON_ON_A) || (byte6 == AIRCON_ON_B)};
      end
      ID_SYNC: begin
        upd.grp   = GRP_SYNC;
        upd.val_a = {1'b0, byte3 == SYNC_ON};
      end
      ID_MODE: begin
        upd.grp   = GRP_MODE;
        upd.val_a = {1'b0, byte4[MODE_DRIVER_BIT]};
        upd.val_b = {1'b0, byte4[MODE_HEAT_BIT]};
      end
      ID_STEER: begin
        upd.grp   = GRP_STEER;
        upd.val_a = {1'b0, byte3 == STEER_ON};
      end
      default: begin
        upd.grp = GRP_NONE;
      end
    endcase
  end

endmodule

@@ src/ccsd_fifo.sv @@
// Short queue of decoded update words between the front and back ends.
module ccsd_fifo
  import ccsd_pkg::*;
#(
  parameter int DEPTH = FIFO_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  upd_t push_data,
  input  logic pop,
  output upd_t head,
  output logic empty,
  output logic full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  upd_t             slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == CNT_W'(DEPTH));
  assign head  = slot_r[rd_ptr_r];

  // Pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  // Checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("queue count above depth");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("pop from empty queue");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into full queue");

endmodule

@@ src/ccsd_back.sv @@
// Back end: applies update words to the cabin status and registers change reports.
module ccsd_back
  import ccsd_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  input  upd_t          q_head,
  output logic          q_pop,
  input  logic          out_stall,
  output logic          out_valid,
  output cabin_status_t out_status
);

  cabin_status_t status_r, status_nxt;
  cabin_status_t out_status_r;
  logic          out_valid_r, out_valid_nxt;
  logic          changed;
  logic          slot_free;

  // Apply the head word to the current status
  always_comb begin
    status_nxt = status_r;
    unique case (q_head.grp)
      GRP_SEAT_FL: begin
        status_nxt.front_left_heat = q_head.val_a;
        status_nxt.front_left_vent = q_head.val_b;
      end
      GRP_SEAT_FR: begin
        status_nxt.front_right_heat = q_head.val_a;
        status_nxt.front_right_vent = q_head.val_b;
      end
      GRP_SEAT_RL: status_nxt.rear_left_heat   = q_head.val_a;
      GRP_SEAT_RR: status_nxt.rear_right_heat  = q_head.val_a;
      GRP_AIRCON:  status_nxt.aircon_on        = q_head.val_a[0];
      GRP_SYNC:    status_nxt.sync_on          = q_head.val_a[0];
      GRP_MODE: begin
        status_nxt.driver_only_on = q_head.val_a[0];
        status_nxt.heat_mode_on   = q_head.val_b[0];
      end
      GRP_STEER:   status_nxt.steering_heat_on = q_head.val_a[0];
      default:     status_nxt = status_r;
    endcase
  end

  assign changed   = (status_nxt != status_r);
  assign slot_free = !out_valid_r || !out_stall;
  // A word that changes nothing can retire even while the output waits
  assign q_pop     = !q_empty && (slot_free || !changed);

  // Output valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (q_pop && changed) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (q_pop) begin
        status_r <= status_nxt;
      end
    end
  end

  // Report word
  always_ff @(posedge clk) begin
    if (q_pop && changed) begin
      out_status_r <= status_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;

  // Checks
  a_report_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_status_r == status_r))
    else $error("pending report differs from stored status");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && changed) |-> slot_free)
    else $error("report overwritten before taken");
  a_quiet_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && !changed) |=> $stable(status_r))
    else $error("status moved on an update without change");

endmodule

@@ src/can_cabin_status_decoder.sv @@
// Top level of the CAN cabin status decoder.
//
// Input channel (in_*): one received standard CAN frame per word: identifier,
// length code and eight data bytes. A word is taken at a rising edge with
// in_valid high and in_stall low. Zero length frames are taken and dropped.
// Output channel (out_*): one status report per frame that changes the stored
// cabin status, carrying all eleven status fields.
// Throughput: one frame per cycle while in_stall is low. The front end
// decodes the frame in the accepting cycle and writes an update word into a
// short queue; the back end retires one queue word per cycle into the status
// register, except a changing word while a stalled report is pending. A
// changing word loads the report register as it retires, so the report is
// valid once the word has left the queue.
// Stall: a pending report holds in the output register while out_stall is high;
// frames that change nothing keep retiring, a changing frame waits in the queue,
// and in_stall rises once the queue is full.
// Reset (rst_n low, synchronous): status cleared to zero, queue emptied, no
// report pending.
module can_cabin_status_decoder
  import ccsd_pkg::*;
#(
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [10:0] in_frame_id,
  input  logic [3:0]  in_length_code,
  input  logic [7:0]  in_byte0,
  input  logic [7:0]  in_byte1,
  input  logic [7:0]  in_byte2,
  input  logic [7:0]  in_byte3,
  input  logic [7:0]  in_byte4,
  input  logic [7:0]  in_byte5,
  input  logic [7:0]  in_byte6,
  input  logic [7:0]  in_byte7,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_front_left_heat,
  output logic [1:0]  out_front_left_vent,
  output logic [1:0]  out_front_right_heat,
  output logic [1:0]  out_front_right_vent,
  output logic [1:0]  out_rear_left_heat,
  output logic [1:0]  out_rear_right_heat,
  output logic        out_aircon_on,
  output logic        out_sync_on,
  output logic        out_driver_only_on,
  output logic        out_heat_mode_on,
  output logic        out_steering_heat_on
);

  upd_t          dec_upd;
  logic          dec_keep;
  logic          q_push;
  logic          q_pop;
  logic          q_empty;
  logic          q_full;
  upd_t          q_head;
  cabin_status_t rpt;
  logic [7:0]    unused_bytes;

  // Bytes 1, 2, 5 and 7 carry nothing decoded
  assign unused_bytes = in_byte1 & in_byte2 & in_byte5 & in_byte7;

  // Front end: decode
  ccsd_front u_front (
    .frame_id    (in_frame_id),
    .length_code (in_length_code),
    .byte0       (in_byte0),
    .byte3       (in_byte3),
    .byte4       (in_byte4),
    .byte6       (in_byte6),
    .keep        (dec_keep),
    .upd         (dec_upd)
  );

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full && dec_keep && (unused_bytes == unused_bytes);

  // Queue between front and back ends
  ccsd_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (dec_upd),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  // Back end: status update and report register
  ccsd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .out_status (rpt)
  );

  assign out_front_left_heat  = rpt.front_left_heat;
  assign out_front_left_vent  = rpt.front_left_vent;
  assign out_front_right_heat = rpt.front_right_heat;
  assign out_front_right_vent = rpt.front_right_vent;
  assign out_rear_left_heat   = rpt.rear_left_heat;
  assign out_rear_right_heat  = rpt.rear_right_heat;
  assign out_aircon_on        = rpt.aircon_on;
  assign out_sync_on          = rpt.sync_on;
  assign out_driver_only_on   = rpt.driver_only_on;
  assign out_heat_mode_on     = rpt.heat_mode_on;
  assign out_steering_heat_on = rpt.steering_heat_on;

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the CAN cabin status decoder: directed and random frames.
module tb_top
  import ccsd_pkg::*;
();

  // One received frame as driven on the input channel
  typedef struct packed {
    logic [10:0] id;
    logic [3:0]  len;
    logic [7:0]  b0, b1, b2, b3, b4, b5, b6, b7;
  } frame_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [10:0] in_frame_id = '0;
  logic [3:0]  in_length_code = '0;
  logic [7:0]  in_byte0 = '0;
  logic [7:0]  in_byte1 = '0;
  logic [7:0]  in_byte2 = '0;
  logic [7:0]  in_byte3 = '0;
  logic [7:0]  in_byte4 = '0;
  logic [7:0]  in_byte5 = '0;
  logic [7:0]  in_byte6 = '0;
  logic [7:0]  in_byte7 = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_front_left_heat;
  logic [1:0]  out_front_left_vent;
  logic [1:0]  out_front_right_heat;
  logic [1:0]  out_front_right_vent;
  logic [1:0]  out_rear_left_heat;
  logic [1:0]  out_rear_right_heat;
  logic        out_aircon_on;
  logic        out_sync_on;
  logic        out_driver_only_on;
  logic        out_heat_mode_on;
  logic        out_steering_heat_on;

  // Predicted cabin status and the reports still owed by the block
  cabin_status_t cabin_now = '0;
  cabin_status_t reports_due[$];
  int            mismatches = 0;
  bit            gaps_on = 1'b1;
  bit            stalls_on = 1'b1;

  can_cabin_status_decoder uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_frame_id         (in_frame_id),
    .in_length_code      (in_length_code),
    .in_byte0            (in_byte0),
    .in_byte1            (in_byte1),
    .in_byte2            (in_byte2),
    .in_byte3            (in_byte3),
    .in_byte4            (in_byte4),
    .in_byte5            (in_byte5),
    .in_byte6            (in_byte6),
    .in_byte7            (in_byte7),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_front_left_heat (out_front_left_heat),
    .out_front_left_vent (out_front_left_vent),
    .out_front_right_heat(out_front_right_heat),
    .out_front_right_vent(out_front_right_vent),
    .out_rear_left_heat  (out_rear_left_heat),
    .out_rear_right_heat (out_rear_right_heat),
    .out_aircon_on       (out_aircon_on),
    .out_sync_on         (out_sync_on),
    .out_driver_only_on  (out_driver_only_on),
    .out_heat_mode_on    (out_heat_mode_on),
    .out_steering_heat_on(out_steering_heat_on)
  );

  // 4-unit clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Front seat code -> {heat, vent}
  function automatic logic [3:0] front_levels(input logic [7:0] code);
    case (code)
      FRONT_HEAT3: return {2'd3, 2'd0};
      FRONT_HEAT2: return {2'd2, 2'd0};
      FRONT_HEAT1: return {2'd1, 2'd0};
      FRONT_VENT3: return {2'd0, 2'd3};
      FRONT_VENT2: return {2'd0, 2'd2};
      FRONT_VENT1: return {2'd0, 2'd1};
      default:     return 4'd0;
    endcase
  endfunction

  // Rear seat code -> heat level
  function automatic logic [1:0] rear_level(input logic [7:0] code);
    case (code)
      REAR_HEAT2: return 2'd2;
      REAR_HEAT1: return 2'd1;
      default:    return 2'd0;
    endcase
  endfunction

  // Apply one accepted frame to the predicted status; queue a report on change
  function automatic void track_frame(input frame_t f);
    cabin_status_t prior;
    logic [3:0]    fv;
    prior = cabin_now;
    if (f.len == 4'd0) return;
    case (f.id)
      ID_SEAT_FL: begin
        fv = front_levels(f.b0);
        cabin_now.front_left_heat = fv[3:2];
        cabin_now.front_left_vent = fv[1:0];
      end
      ID_SEAT_FR: begin
        fv = front_levels(f.b0);
        cabin_now.front_right_heat = fv[3:2];
        cabin_now.front_right_vent = fv[1:0];
      end
      ID_REAR_LEFT:  cabin_now.rear_left_heat = rear_level(f.b0);
      ID_REAR_RIGHT: cabin_now.rear_right_heat = rear_level(f.b0);
      ID_AIRCON:  cabin_now.aircon_on = (f.b6 == AIRCON_ON_A) || (f.b6 == AIRCON_ON_B);
      ID_SYNC:    cabin_now.sync_on = (f.b3 == SYNC_ON);
      ID_MODE: begin
        cabin_now.driver_only_on = f.b4[MODE_DRIVER_BIT];
        cabin_now.heat_mode_on   = f.b4[MODE_HEAT_BIT];
      end
      ID_STEER:   cabin_now.steering_heat_on = (f.b3 == STEER_ON);
      default: ;
    endcase
    if (cabin_now != prior) reports_due.push_back(cabin_now);
  endfunction

  // Send one word; returns at the falling edge after it was taken
  task automatic send_frame(input frame_t f);
    while (gaps_on && $urandom_range(99) < 28) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_frame_id    <= f.id;
    in_length_code <= f.len;
    in_byte0 <= f.b0;
    in_byte1 <= f.b1;
    in_byte2 <= f.b2;
    in_byte3 <= f.b3;
    in_byte4 <= f.b4;
    in_byte5 <= f.b5;
    in_byte6 <= f.b6;
    in_byte7 <= f.b7;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    track_frame(f);
    @(negedge clk);
  endtask

  // Frame with the decoded bytes given and the unused bytes random
  function automatic frame_t frame_of(input logic [10:0] id, input logic [3:0] len,
                                      input logic [7:0] b0, input logic [7:0] b3,
                                      input logic [7:0] b4, input logic [7:0] b6);
    frame_t f;
    f.id = id;
    f.len = len;
    f.b0 = b0;
    f.b1 = 8'($urandom);
    f.b2 = 8'($urandom);
    f.b3 = b3;
    f.b4 = b4;
    f.b5 = 8'($urandom);
    f.b6 = b6;
    f.b7 = 8'($urandom);
    return f;
  endfunction

  function automatic logic [10:0] known_id(input int k);
    case (k)
      0:       return ID_SEAT_FL;
      1:       return ID_SEAT_FR;
      2:       return ID_REAR_LEFT;
      3:       return ID_REAR_RIGHT;
      4:       return ID_AIRCON;
      5:       return ID_SYNC;
      6:       return ID_MODE;
      default: return ID_STEER;
    endcase
  endfunction

  function automatic logic [7:0] front_code(input int k);
    case (k)
      0:       return FRONT_HEAT3;
      1:       return FRONT_HEAT2;
      2:       return FRONT_HEAT1;
      3:       return FRONT_VENT3;
      4:       return FRONT_VENT2;
      5:       return FRONT_VENT1;
      default: return 8'($urandom);
    endcase
  endfunction

  // Mostly well-formed status frames, some noise and some zero-length frames
  function automatic frame_t random_frame();
    frame_t f;
    int     pick;
    f = frame_of(11'($urandom_range(2047)), 4'($urandom_range(15)), 8'($urandom),
                 8'($urandom), 8'($urandom), 8'($urandom));
    pick = $urandom_range(99);
    if (pick < 72) begin
      f.id = known_id($urandom_range(7));
      f.len = ($urandom_range(3) == 0) ? 4'($urandom_range(15, 1)) : 4'd8;
      if ($urandom_range(4) != 0) begin
        case (f.id)
          ID_SEAT_FL, ID_SEAT_FR: f.b0 = front_code($urandom_range(6));
          ID_REAR_LEFT, ID_REAR_RIGHT:
            f.b0 = ($urandom_range(1) != 0) ? REAR_HEAT2 : REAR_HEAT1;
          ID_AIRCON: f.b6 = ($urandom_range(1) != 0) ? AIRCON_ON_A : AIRCON_ON_B;
          ID_SYNC:   f.b3 = SYNC_ON;
          ID_STEER:  f.b3 = STEER_ON;
          default: ;
        endcase
      end
    end else if (pick >= 86) begin
      f.id = known_id($urandom_range(7));
      f.len = 4'd0;
    end
    return f;
  endfunction

  // Output side: random stall, driven at the falling edge
  always @(negedge clk) begin
    out_stall <= stalls_on && ($urandom_range(99) < 28);
  end

  task automatic check_field(input string name, input logic [1:0] want, input logic [1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Compare each taken report with the oldest expected one
  always @(posedge clk) begin : check_reports
    cabin_status_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (reports_due.size() == 0) begin
        $error("report with no expected status pending");
        mismatches++;
      end else begin
        want = reports_due.pop_front();
        check_field("front_left_heat", want.front_left_heat, out_front_left_heat);
        check_field("front_left_vent", want.front_left_vent, out_front_left_vent);
        check_field("front_right_heat", want.front_right_heat, out_front_right_heat);
        check_field("front_right_vent", want.front_right_vent, out_front_right_vent);
        check_field("rear_left_heat", want.rear_left_heat, out_rear_left_heat);
        check_field("rear_right_heat", want.rear_right_heat, out_rear_right_heat);
        check_field("aircon_on", want.aircon_on, out_aircon_on);
        check_field("sync_on", want.sync_on, out_sync_on);
        check_field("driver_only_on", want.driver_only_on, out_driver_only_on);
        check_field("heat_mode_on", want.heat_mode_on, out_heat_mode_on);
        check_field("steering_heat_on", want.steering_heat_on, out_steering_heat_on);
      end
    end
  end

  // Every seat code, repeated value, short and long length codes
  task automatic test_seat_levels();
    send_frame(frame_of(ID_SEAT_FL, 4'd8, FRONT_HEAT3, 8'h00, 8'h00, 8'h00));
    send_frame(frame_of(ID_SEAT_FL, 4'd8, FRONT_HEAT3, 8'hFF, 8'hFF, 8'hFF));
    send_frame(frame_of(ID_SEAT_FL, 4'd1, FRONT_VENT3, 8'h00, 8'h00, 8'h00));
    send_frame(frame_of(ID_SEAT_FL, 4'd15, FRONT_VENT2, 8'h00, 8'h00, 8'h00));
    send_frame(frame_of(ID_SEAT_FL, 4'd7, FRONT_VENT1, 8'h00, 8'h00, 8'h00));
    send_frame(frame_of(ID_SEAT_FL, 4'd8, FRONT_HEAT2, 8'h00, 8'h00, 8'h00));
    send_frame(frame_of(ID_SEAT_FL, 4'd8, FRONT_HEAT1, 8'h00, 8'h00, 8'h00));
    send_frame(frame_of(ID_SEAT_FR, 4'd8, FRONT_HEAT3, 8'h00, 8'h00, 8'h00));
    send_frame(frame_of(ID_SEAT_FR, 4'd8, 8'hFF, 8'h00, 8'h00, 8'h00));
    send_frame(frame_of(ID_REAR_LEFT, 4'd8, REAR_HEAT2, 8'h00, 8'h00, 8'h00));
    send_frame(frame_of(ID_REAR_LEFT, 4'd8, REAR_HEAT1, 8'h00, 8'h00, 8'h00));
    send_frame(frame_of(ID_REAR_RIGHT, 4'd8, REAR_HEAT2, 8'h00, 8'h00, 8'h00));
    send_frame(frame_of(ID_REAR_RIGHT, 4'd8, 8'h00, 8'h00, 8'h00, 8'h00));
  endtask

  // A/C, sync, mode bits and steering heat, on and off
  task automatic test_climate_flags();
    send_frame(frame_of(ID_AIRCON, 4'd8, 8'h00, 8'h00, 8'h00, AIRCON_ON_A));
    send_frame(frame_of(ID_AIRCON, 4'd8, 8'h00, 8'h00, 8'h00, AIRCON_ON_B));
    send_frame(frame_of(ID_AIRCON, 4'd8, 8'h00, 8'h00, 8'h00, 8'h00));
    send_frame(frame_of(ID_SYNC, 4'd8, 8'h00, SYNC_ON, 8'h00, 8'h00));
    send_frame(frame_of(ID_SYNC, 4'd8, 8'h00, 8'h11, 8'h00, 8'h00));
    send_frame(frame_of(ID_MODE, 4'd8, 8'h00, 8'h00, 8'h11, 8'h00));
    send_frame(frame_of(ID_MODE, 4'd8, 8'h00, 8'h00, 8'hEE, 8'h00));
    send_frame(frame_of(ID_MODE, 4'd8, 8'h00, 8'h00, 8'h10, 8'h00));
    send_frame(frame_of(ID_STEER, 4'd8, 8'h00, STEER_ON, 8'h00, 8'h00));
    send_frame(frame_of(ID_STEER, 4'd8, 8'h00, 8'hFF, 8'h00, 8'h00));
  endtask

  // Zero length and unknown identifiers at both ends of the range
  task automatic test_ignored_frames();
    send_frame(frame_of(ID_SEAT_FL, 4'd0, FRONT_HEAT3, 8'h00, 8'h00, 8'h00));
    send_frame(frame_of(11'h7FF, 4'd15, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_frame(frame_of(11'h000, 4'd8, 8'h00, 8'h00, 8'h00, 8'h00));
  endtask

  task automatic test_random_with_gaps();
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    repeat (1400) send_frame(random_frame());
  endtask

  // Long stretch with no idling on either side
  task automatic test_random_streaming();
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    repeat (600) send_frame(random_frame());
    gaps_on = 1'b1;
    stalls_on = 1'b1;
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_seat_levels();
    test_climate_flags();
    test_ignored_frames();
    test_random_with_gaps();
    test_random_streaming();
    in_valid <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Run limit
  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ sim.f @@
src/ccsd_pkg.sv
src/ccsd_front.sv
src/ccsd_fifo.sv
src/ccsd_back.sv
src/can_cabin_status_decoder.sv
tb/tb_top.sv
